// ----- src/mrq_pkg.sv -----
`timescale 1ns / 1ps

package mrq_pkg;

    localparam int ID_W   = 6;
    localparam int PRIO_W = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_CHANGE = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_DONE       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_QUEUED = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [ST_W-1:0] ST_QUEUED     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [ID_W-1:0]          thread_id;
        logic signed [PRIO_W-1:0] priority_req;
    } mrq_req_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [ID_W-1:0] picked_id;
        logic            picked_valid;
    } mrq_rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic            accept;
        logic            clr_step;
        logic            pick_sel;
        logic            info_chk;
        logic            pick_head;
        logic            unlink_wr;
        logic            link_rd;
        logic            link_wr;
        logic            set_status;
        logic [ST_W-1:0] status_code;
        logic            rsp_load;
    } mrq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_bad;
        logic            queued;
        logic            mask_empty;
        logic            clr_last;
        logic            out_free;
    } mrq_stat_t;

endpackage

// ----- src/multilevel_ready_queue.sv -----
`timescale 1ns / 1ps

// Multilevel ready queue: one FIFO list of thread ids per priority level.
// Request channel (req_valid / req_stall / req_data) carries one item:
// operation (add, remove, pick next, change priority), thread id and
// priority. Response channel (rsp_valid / rsp_stall / rsp_data) returns
// exactly one item per request: status, picked id and picked flag.
// A bad id, an empty pick and a refused add or remove skip the link steps;
// add links the thread in, remove unlinks it, pick unlinks the head of the
// highest nonempty level, and change of a queued thread's priority unlinks
// and relinks it. The next request is taken in the cycle after the response
// is registered; the sequencer serializes the registered-read link memories.
// After reset the block sweeps the per-thread flag memory with req_stall
// high; then it starts taking requests. A stalled response holds in the
// output register; the block still takes and works on one more request and
// then waits until the register frees.
module multilevel_ready_queue #(
    parameter int LEVELS  = 8,
    parameter int THREADS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mrq_pkg::mrq_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output mrq_pkg::mrq_rsp_t rsp_data
);

    import mrq_pkg::*;

    // Command and status between sequencer and datapath
    mrq_cmd_t  cmd;
    mrq_stat_t stat;

    // Sequencer: walks each operation through read and write steps
    mrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: link, level-end and flag memories, level mask, result register
    mrq_datapath #(
        .LEVELS  (LEVELS),
        .THREADS (THREADS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- src/mrq_ram.sv -----
`timescale 1ns / 1ps

module mrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mrq_ctrl.sv -----
`timescale 1ns / 1ps

module mrq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output mrq_pkg::mrq_cmd_t  cmd,
    input  mrq_pkg::mrq_stat_t stat
);

    import mrq_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_INFO_RD  = 12'b0000_0000_0100,
        S_INFO_CHK = 12'b0000_0000_1000,
        S_PICK_RD  = 12'b0000_0001_0000,
        S_PICK_HD  = 12'b0000_0010_0000,
        S_UNL_RD   = 12'b0000_0100_0000,
        S_UNL_WR   = 12'b0000_1000_0000,
        S_LNK_RD   = 12'b0001_0000_0000,
        S_LNK_WR   = 12'b0010_0000_0000,
        S_RESP     = 12'b0100_0000_0000,
        S_SPARE    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_INFO_RD;
                end
            end
            S_INFO_RD:
            begin
                if (stat.op == OP_PICK)
                begin
                    if (stat.mask_empty)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_EMPTY;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        cmd.pick_sel = 1'b1;
                        state_next   = S_PICK_RD;
                    end
                end
                else if (stat.id_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_QUEUED;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_INFO_CHK;
                end
            end
            S_INFO_CHK:
            begin
                cmd.info_chk = 1'b1;
                case (stat.op)
                    OP_ADD:
                    begin
                        if (stat.queued)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_QUEUED;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_LNK_RD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (stat.queued)
                        begin
                            state_next = S_UNL_RD;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOT_QUEUED;
                            state_next      = S_RESP;
                        end
                    end
                    OP_CHANGE:
                    begin
                        state_next = stat.queued ? S_UNL_RD : S_LNK_RD;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_PICK_RD:
            begin
                state_next = S_PICK_HD;
            end
            S_PICK_HD:
            begin
                cmd.pick_head = 1'b1;
                state_next    = S_UNL_RD;
            end
            S_UNL_RD:
            begin
                state_next = S_UNL_WR;
            end
            S_UNL_WR:
            begin
                cmd.unlink_wr = 1'b1;
                state_next    = (stat.op == OP_CHANGE) ? S_LNK_RD : S_RESP;
            end
            S_LNK_RD:
            begin
                cmd.link_rd = 1'b1;
                state_next  = S_LNK_WR;
            end
            S_LNK_WR:
            begin
                cmd.link_wr = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The clearing sweep runs once after reset only
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clearing sweep re-entered");

endmodule

// ----- src/mrq_datapath.sv -----
`timescale 1ns / 1ps

module mrq_datapath #(
    parameter int LEVELS  = 8,
    parameter int THREADS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mrq_pkg::mrq_req_t  req_data,
    input  logic               rsp_stall,
    output logic               rsp_valid,
    output mrq_pkg::mrq_rsp_t  rsp_data,
    input  mrq_pkg::mrq_cmd_t  cmd,
    output mrq_pkg::mrq_stat_t stat
);

    import mrq_pkg::*;

    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IW  = $clog2(THREADS);
    localparam int AW  = $clog2(THREADS + 1);
    localparam int FW  = LW + 1;
    localparam int DIV = 100 / LEVELS;
    localparam logic [AW-1:0] NIL = AW'(THREADS);

    // Item registers
    logic [OP_W-1:0]   op_reg;
    logic [AW-1:0]     tgt_reg;
    logic              id_bad_reg;
    logic [LW-1:0]     lvn_reg;
    logic [LW-1:0]     lv_old_reg;
    logic [ST_W-1:0]   status_reg;
    logic [ID_W-1:0]   picked_id_reg;
    logic              picked_valid_reg;
    mrq_rsp_t          rsp_data_reg;

    // Control registers
    logic [LEVELS-1:0] mask_reg;
    logic [LEVELS-1:0] mask_next;
    logic [IW-1:0]     clr_cnt_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    logic signed [PRIO_W-1:0] prio_in;
    logic [LW-1:0]     lvn_calc;
    logic [LW-1:0]     pick_lv;

    // Memory ports
    logic              next_we, prev_we, info_we, head_we, tail_we;
    logic [IW-1:0]     next_waddr, prev_waddr, info_waddr;
    logic [LW-1:0]     head_waddr, tail_waddr;
    logic [AW-1:0]     next_wdata, prev_wdata, head_wdata, tail_wdata;
    logic [FW-1:0]     info_wdata;
    logic [AW-1:0]     next_rdata, prev_rdata, head_rdata, tail_rdata;
    logic [FW-1:0]     info_rdata;

    logic              p_ok, n_ok, old_ok;
    logic [AW-1:0]     link_old;

    assign prio_in = req_data.priority_req;

    // Level is the count of band thresholds reached; negative stays at zero
    always_comb
    begin
        lvn_calc = '0;
        for (int k = 1; k < LEVELS; k++)
        begin
            if (int'(prio_in) >= k * DIV)
            begin
                lvn_calc = LW'(k);
            end
        end
    end

    // Highest nonempty level
    always_comb
    begin
        pick_lv = '0;
        for (int k = 0; k < LEVELS; k++)
        begin
            if (mask_reg[k])
            begin
                pick_lv = LW'(k);
            end
        end
    end

    mrq_ram #(.WIDTH(AW), .DEPTH(THREADS)) u_next_mem (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (tgt_reg[IW-1:0]),
        .rdata (next_rdata)
    );

    mrq_ram #(.WIDTH(AW), .DEPTH(THREADS)) u_prev_mem (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (tgt_reg[IW-1:0]),
        .rdata (prev_rdata)
    );

    mrq_ram #(.WIDTH(FW), .DEPTH(THREADS)) u_info_mem (
        .clk   (clk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .raddr (tgt_reg[IW-1:0]),
        .rdata (info_rdata)
    );

    mrq_ram #(.WIDTH(AW), .DEPTH(LEVELS)) u_head_mem (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (lv_old_reg),
        .rdata (head_rdata)
    );

    mrq_ram #(.WIDTH(AW), .DEPTH(LEVELS)) u_tail_mem (
        .clk   (clk),
        .we    (tail_we),
        .waddr (tail_waddr),
        .wdata (tail_wdata),
        .raddr (lvn_reg),
        .rdata (tail_rdata)
    );

    assign p_ok     = (prev_rdata < NIL);
    assign n_ok     = (next_rdata < NIL);
    assign old_ok   = mask_reg[lvn_reg];
    assign link_old = old_ok ? tail_rdata : NIL;

    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = '0;
        next_wdata = '0;
        prev_we    = 1'b0;
        prev_waddr = '0;
        prev_wdata = '0;
        head_we    = 1'b0;
        head_waddr = '0;
        head_wdata = '0;
        tail_we    = 1'b0;
        tail_waddr = '0;
        tail_wdata = '0;
        info_we    = 1'b0;
        info_waddr = '0;
        info_wdata = '0;
        mask_next  = mask_reg;

        if (cmd.clr_step)
        begin
            info_we    = 1'b1;
            info_waddr = clr_cnt_reg;
            info_wdata = '0;
        end

        // Splice the target out: bridge its neighbors or move the level ends
        if (cmd.unlink_wr)
        begin
            if (p_ok)
            begin
                next_we    = 1'b1;
                next_waddr = prev_rdata[IW-1:0];
                next_wdata = next_rdata;
            end
            else
            begin
                head_we    = 1'b1;
                head_waddr = lv_old_reg;
                head_wdata = next_rdata;
                mask_next[lv_old_reg] = n_ok;
            end
            if (n_ok)
            begin
                prev_we    = 1'b1;
                prev_waddr = next_rdata[IW-1:0];
                prev_wdata = prev_rdata;
            end
            else
            begin
                tail_we    = 1'b1;
                tail_waddr = lv_old_reg;
                tail_wdata = prev_rdata;
            end
            info_we    = 1'b1;
            info_waddr = tgt_reg[IW-1:0];
            info_wdata = {1'b0, lv_old_reg};
        end

        // Terminate the new tail while the old tail is read
        if (cmd.link_rd)
        begin
            next_we    = 1'b1;
            next_waddr = tgt_reg[IW-1:0];
            next_wdata = NIL;
        end

        if (cmd.link_wr)
        begin
            prev_we    = 1'b1;
            prev_waddr = tgt_reg[IW-1:0];
            prev_wdata = link_old;
            if (old_ok)
            begin
                next_we    = 1'b1;
                next_waddr = link_old[IW-1:0];
                next_wdata = tgt_reg;
            end
            else
            begin
                head_we    = 1'b1;
                head_waddr = lvn_reg;
                head_wdata = tgt_reg;
            end
            tail_we    = 1'b1;
            tail_waddr = lvn_reg;
            tail_wdata = tgt_reg;
            info_we    = 1'b1;
            info_waddr = tgt_reg[IW-1:0];
            info_wdata = {1'b1, lvn_reg};
            mask_next[lvn_reg] = 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg           <= req_data.operation;
            tgt_reg          <= AW'(req_data.thread_id);
            id_bad_reg       <= (int'(req_data.thread_id) >= THREADS);
            lvn_reg          <= lvn_calc;
            status_reg       <= ST_DONE;
            picked_id_reg    <= '0;
            picked_valid_reg <= 1'b0;
        end
        if (cmd.pick_sel)
        begin
            lv_old_reg <= pick_lv;
        end
        if (cmd.info_chk)
        begin
            lv_old_reg <= info_rdata[LW-1:0];
        end
        if (cmd.pick_head)
        begin
            tgt_reg          <= head_rdata;
            picked_id_reg    <= ID_W'(head_rdata);
            picked_valid_reg <= 1'b1;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.rsp_load)
        begin
            rsp_data_reg.status       <= status_reg;
            rsp_data_reg.picked_id    <= picked_id_reg;
            rsp_data_reg.picked_valid <= picked_valid_reg;
        end
    end

    assign stat.op         = op_reg;
    assign stat.id_bad     = id_bad_reg;
    assign stat.queued     = info_rdata[FW-1];
    assign stat.mask_empty = (mask_reg == '0);
    assign stat.clr_last   = (clr_cnt_reg == IW'(THREADS - 1));
    assign stat.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.link_wr && old_ok) |-> (tail_rdata != tgt_reg))
        else $error("thread linked behind itself");

    a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick_head |-> mask_reg[lv_old_reg])
        else $error("head taken from an empty level");

    a_unlink_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.unlink_wr |-> mask_reg[lv_old_reg])
        else $error("unlink from an empty level");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("pending result overwritten");

endmodule
